@@ rtl/spmf_pkg.sv @@
`default_nettype none

package spmf_pkg;

   localparam int NUM_QUEUES   = 4;
   localparam int QUEUE_DEPTH  = 64;
   localparam int HANDLE_WIDTH = 32;

   // field widths of the ports
   localparam int CAP_W   = 7;
   localparam int CLASS_W = 2;
   localparam int HDL_W   = 32;

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   typedef enum logic {
      MODE_ENQ = 1'b0,
      MODE_DEQ = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_DEQUEUED = 2'd2,
      ST_NOTHING  = 2'd3
   } status_type;

   typedef struct packed {
      mode_type               mode;
      logic [CLASS_W-1:0]     class_index;
      logic [HDL_W-1:0]       packet_handle;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [HDL_W-1:0]       out_handle;
      logic [CLASS_W-1:0]     out_class;
      logic                   all_empty;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/spmf_ctrl.sv @@
`default_nettype none

module spmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spmf_pkg::dp_stat_type stat,
   output spmf_pkg::ctl_cmd_type cmd
);
   import spmf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/spmf_datapath.sv @@
`default_nettype none

module spmf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  spmf_pkg::ctl_cmd_type         cmd,
   output spmf_pkg::dp_stat_type         stat,
   input  logic                          csr_we,
   input  logic [spmf_pkg::CAP_W-1:0]    csr_wdata,
   input  spmf_pkg::req_type             req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spmf_pkg::rsp_type             rsp
);
   import spmf_pkg::*;

   // registers
   req_type                  req_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [PTR_W-1:0]         head_ff [NUM_QUEUES];
   logic [PTR_W-1:0]         tail_ff [NUM_QUEUES];
   logic [CNT_W-1:0]         cnt_ff  [NUM_QUEUES];
   logic [PTR_W-1:0]         head_in [NUM_QUEUES];
   logic [PTR_W-1:0]         tail_in [NUM_QUEUES];
   logic [CNT_W-1:0]         cnt_in  [NUM_QUEUES];
   logic [HANDLE_WIDTH-1:0]  mem [NUM_QUEUES * QUEUE_DEPTH];
   logic [HANDLE_WIDTH-1:0]  rd_data_ff;
   status_type               op_status_ff, op_status_in;
   logic [CLASS_W-1:0]       op_class_ff, op_class_in;
   logic [HDL_W-1:0]         op_hdl_ff, op_hdl_in;
   logic                     op_pop_ff, op_pop_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   // execute-stage decode
   logic [QIDX_W-1:0]        enq_q, deq_q;
   logic                     in_range, full, any_ne, do_push, do_pop, none_left;
   logic [CNT_W-1:0]         cnt_sel;
   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      if (32'(p) == QUEUE_DEPTH - 1) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   assign enq_q    = QIDX_W'(req_ff.class_index);
   assign in_range = 32'(req_ff.class_index) < NUM_QUEUES;
   assign cnt_sel  = in_range ? cnt_ff[enq_q] : '0;
   assign full     = (32'(cnt_sel) >= QUEUE_DEPTH) ||
                     ((cap_ff != '0) && (32'(cnt_sel) >= 32'(cap_ff)));

   // strict priority: lowest-numbered non-empty queue wins
   always_comb begin
      any_ne = 1'b0;
      deq_q  = '0;
      for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
         if (cnt_ff[q] != '0) begin
            any_ne = 1'b1;
            deq_q  = QIDX_W'(q);
         end
      end
   end

   assign do_push = cmd.exec && (req_ff.mode == MODE_ENQ) && in_range && !full;
   assign do_pop  = cmd.exec && (req_ff.mode == MODE_DEQ) && any_ne;
   assign mem_we  = do_push;
   assign mem_re  = do_pop;
   assign wr_addr = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[enq_q]);
   assign rd_addr = ADDR_W'(deq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[deq_q]);

   always_comb begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_in[q] = head_ff[q];
         tail_in[q] = tail_ff[q];
         cnt_in[q]  = cnt_ff[q];
      end
      if (do_push) begin
         tail_in[enq_q] = advance(tail_ff[enq_q]);
         cnt_in[enq_q]  = cnt_ff[enq_q] + CNT_W'(1);
      end
      if (do_pop) begin
         head_in[deq_q] = advance(head_ff[deq_q]);
         cnt_in[deq_q]  = cnt_ff[deq_q] - CNT_W'(1);
      end
   end

   always_comb begin
      op_pop_in    = 1'b0;
      op_hdl_in    = '0;
      op_class_in  = '0;
      op_status_in = ST_NOTHING;
      if (req_ff.mode == MODE_ENQ) begin
         op_class_in = req_ff.class_index;
         if (!in_range || full) begin
            op_status_in = ST_DROPPED;
            op_hdl_in    = HDL_W'(HANDLE_WIDTH'(req_ff.packet_handle));
         end else begin
            op_status_in = ST_ENQUEUED;
         end
      end else if (any_ne) begin
         op_status_in = ST_DEQUEUED;
         op_class_in  = CLASS_W'(deq_q);
         op_pop_in    = 1'b1;
      end
   end

   always_comb begin
      none_left = 1'b1;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (cnt_ff[q] != '0) begin
            none_left = 1'b0;
         end
      end
   end

   // handle store, registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= HANDLE_WIDTH'(req_ff.packet_handle);
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req;
      end
      if (cmd.exec) begin
         op_status_ff <= op_status_in;
         op_class_ff  <= op_class_in;
         op_hdl_ff    <= op_hdl_in;
         op_pop_ff    <= op_pop_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status     <= op_status_ff;
         rsp_ff.out_handle <= op_pop_ff ? HDL_W'(rd_data_ff) : op_hdl_ff;
         rsp_ff.out_class  <= op_class_ff;
         rsp_ff.all_empty  <= none_left;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= head_in[q];
            tail_ff[q] <= tail_in[q];
            cnt_ff[q]  <= cnt_in[q];
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/strict_priority_multi_fifo_core.sv @@
// Channel  Direction  Handshake           Beat
// req      in         req_valid/stall     mode, class_index, packet_handle
// rsp      out        rsp_valid/stall     status, out_handle, out_class, all_empty
// csr      in         csr_we (no stall)   frame_capacity
//
// One item at a time: capture, execute (queue update plus
// launch of the handle store read), load of the result register once free.
// The registered read port of the handle store sets the execute/result split.
// A stalled rsp holds the finished beat; the next req beat is still taken, its
// result waits in the datapath until the output register frees.
// Sync reset empties all queues and clears frame_capacity; stored handles are
// not cleared (an entry is only read after it has been written).
`default_nettype none

module strict_priority_multi_fifo_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  spmf_pkg::req_type              req,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output spmf_pkg::rsp_type              rsp,
   input  logic                           csr_we,
   input  logic [spmf_pkg::CAP_W-1:0]     csr_wdata
);
   import spmf_pkg::*;

   ctl_cmd_type cmd;    // step strobes from the FSM
   dp_stat_type stat;   // output register availability

   spmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spmf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

@@ rtl/spmf_checker.sv @@
`default_nettype none

module spmf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input spmf_pkg::rsp_type           rsp
);
   import spmf_pkg::*;

   // one beat in flight: input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted while previous beat in flight");

   // a new result only appears while an item is being worked on
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp beat without an accepted req");

   a_nothing_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ST_NOTHING |->
         rsp.out_handle == '0 && rsp.out_class == '0 && rsp.all_empty)
      else $error("empty dequeue beat carries data");

   a_enq_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ST_ENQUEUED |->
         !rsp.all_empty && rsp.out_handle == '0)
      else $error("enqueue beat reports empty or handle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled rsp beat changed");

endmodule

bind strict_priority_multi_fifo_core spmf_checker u_spmf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire

@@ test/tb_strict_priority_multi_fifo_core.sv @@
`timescale 1ns / 1ps

module tb_strict_priority_multi_fifo_core;
   import spmf_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 8;        // idle margin after the last result
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp;
   logic              csr_we;
   logic [CAP_W-1:0]  csr_wdata;

   strict_priority_multi_fifo_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shared state: beats waiting to be sent, predicted results in order,
   // and the mirror of the per-class queues plus the capacity register.
   // ---------------------------------------------------------------------
   req_type           pending_beats [$];
   rsp_type           expected_rsp  [$];
   logic [HDL_W-1:0]  class_fifo    [NUM_QUEUES][$];
   logic [CAP_W-1:0]  cap_model;

   int unsigned       error_count;
   int unsigned       cycle_count;
   int unsigned       n_enqueued, n_dropped, n_dequeued, n_idle_deq;
   logic              req_taken;            // beat accepted at the last rising edge

   int unsigned       burst_left;
   int unsigned       gap_left;
   int unsigned       stall_style;
   int unsigned       stall_span;

   // clock and reset
   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req       = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp.size());
         $display("** strict_priority_multi_fifo_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor: applies one accepted beat to the queue mirror and returns
   // the result the block must produce for it.
   // ---------------------------------------------------------------------
   function automatic rsp_type apply_queue_op(req_type beat);
      rsp_type      res;
      int unsigned  c;
      int           q;
      bit           served;
      res    = '0;
      served = 1'b0;
      if (beat.mode == MODE_ENQ) begin
         // class_index is 2 bits wide and all 4 queues exist, so it is always in range
         c             = beat.class_index;
         res.out_class = beat.class_index;
         if (class_fifo[c].size() >= QUEUE_DEPTH ||
             (cap_model != 0 && class_fifo[c].size() >= cap_model)) begin
            // tail drop: capacity reached, or physically full for any capacity
            res.status     = ST_DROPPED;
            res.out_handle = beat.packet_handle;
         end else begin
            class_fifo[c].push_back(beat.packet_handle);
            res.status = ST_ENQUEUED;
         end
      end else begin
         res.status = ST_NOTHING;
         for (q = 0; q < NUM_QUEUES; q++) begin
            if (!served && class_fifo[q].size() != 0) begin
               res.out_handle = class_fifo[q].pop_front();
               res.out_class  = q[CLASS_W-1:0];
               res.status     = ST_DEQUEUED;
               served         = 1'b1;
            end
         end
      end
      res.all_empty = 1'b1;
      for (q = 0; q < NUM_QUEUES; q++)
         if (class_fifo[q].size() != 0)
            res.all_empty = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [HDL_W-1:0] want, logic [HDL_W-1:0] got);
      error_count++;
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. A new beat is
   // predicted before any result is checked so ordering stays oldest-first.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            want = apply_queue_op(req);
            expected_rsp.push_back(want);
            case (want.status)
               ST_ENQUEUED: n_enqueued++;
               ST_DROPPED:  n_dropped++;
               ST_DEQUEUED: n_dequeued++;
               default:     n_idle_deq++;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected result beat", '0, rsp.out_handle);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", HDL_W'(want.status), HDL_W'(rsp.status));
               if (rsp.out_handle !== want.out_handle)
                  report_mismatch("out_handle", want.out_handle, rsp.out_handle);
               if (rsp.out_class !== want.out_class)
                  report_mismatch("out_class", HDL_W'(want.out_class),
                                  HDL_W'(rsp.out_class));
               if (rsp.all_empty !== want.all_empty)
                  report_mismatch("all_empty", HDL_W'(want.all_empty),
                                  HDL_W'(rsp.all_empty));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of random length with random gaps; a beat is held
   // until it is taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 24);
         gap_left   <= 0;
      end else if (req_valid && !req_taken) begin
         // stalled: keep valid and payload
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_beats.size() != 0) begin
         req       <= pending_beats.pop_front();
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result-side stall: a style held for a random span (none, light, half, heavy)
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_span  <= $urandom_range(10, 80);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_style)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   // checked at the rising edge, where the driver's queue and valid are settled
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      cap_model  = value;
      @(posedge clock);
   endtask

   task automatic push_beat(mode_type m, int unsigned cls, logic [HDL_W-1:0] handle);
      req_type b;
      b.mode          = m;
      b.class_index   = cls[CLASS_W-1:0];
      b.packet_handle = handle;
      pending_beats.push_back(b);
   endtask

   // random traffic; fav_class >= 0 steers most enqueues to one class so it fills up
   task automatic traffic_phase(logic [CAP_W-1:0] cap, int n, int enq_pct, int fav_class);
      int i;
      int unsigned cls;
      wait_idle();
      write_capacity(cap);
      for (i = 0; i < n; i++) begin
         if (fav_class >= 0 && $urandom_range(0, 99) < 70)
            cls = fav_class;
         else
            cls = $urandom_range(0, NUM_QUEUES - 1);
         push_beat(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ, cls, $urandom);
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      n_enqueued  = 0;
      n_dropped   = 0;
      n_dequeued  = 0;
      n_idle_deq  = 0;
      req_taken   = 1'b0;
      stall_style = 0;
      stall_span  = 0;
      cap_model   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty dequeue, handle extremes, priority order across all classes
      push_beat(MODE_DEQ, 2, 32'hFFFF_FFFF);
      push_beat(MODE_ENQ, 3, 32'hFFFF_FFFF);
      push_beat(MODE_ENQ, 0, 32'h0000_0000);
      push_beat(MODE_ENQ, 2, 32'h5A5A_5A5A);
      push_beat(MODE_ENQ, 1, 32'hA5A5_A5A5);
      push_beat(MODE_ENQ, 0, 32'h1234_5678);
      repeat (6) push_beat(MODE_DEQ, 0, 32'h0);

      // directed: capacity of one drops the second entry of a class
      wait_idle();
      write_capacity(1);
      push_beat(MODE_ENQ, 1, 32'h0000_0001);
      push_beat(MODE_ENQ, 1, 32'h8000_0000);
      push_beat(MODE_ENQ, 3, 32'h0F0F_0F0F);
      push_beat(MODE_ENQ, 3, 32'hF0F0_F0F0);
      repeat (3) push_beat(MODE_DEQ, 3, 32'hDEAD_BEEF);

      // random part; each phase change waits for every result (config only while idle)
      traffic_phase(7'd64,  150, 60, -1);
      traffic_phase(7'd0,   200, 85,  0);   // class 0 hits physical depth
      traffic_phase(7'd3,   150, 55, -1);
      traffic_phase(7'd127, 200, 85,  2);   // capacity above depth: depth still rules
      traffic_phase(7'd1,   150, 50, -1);
      traffic_phase(7'd17,  150, 65,  3);
      traffic_phase(7'd0,   200, 15, -1);   // mostly drains, many empty dequeues

      wait_idle();
      $display("covered %0d beats: %0d enqueued, %0d dropped, %0d dequeued, %0d empty dequeues",
               n_enqueued + n_dropped + n_dequeued + n_idle_deq,
               n_enqueued, n_dropped, n_dequeued, n_idle_deq);
      $display("capacities 0, 1, 3, 17, 64 and 127 used; %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("** strict_priority_multi_fifo_core: PASSED **");
      end else begin
         $display("** strict_priority_multi_fifo_core: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/spmf_pkg.sv
rtl/spmf_ctrl.sv
rtl/spmf_datapath.sv
rtl/strict_priority_multi_fifo_core.sv
rtl/spmf_checker.sv
test/tb_strict_priority_multi_fifo_core.sv
